// File: hw/rtl/chs_pkg.sv
// Shared types and constants for the cosine hemisphere sampler.
// Holds the input and result word structs and the fixed-point constants.
// No dependencies.
package chs_pkg;

    localparam int FRAC_BITS = 22;
    localparam int IN_BITS   = 24;
    localparam int TRIG_BITS = 30;
    localparam int REM_BITS  = 21;
    localparam int NSTEP     = 6;

    // pi * 2^32, and 1/pi * 2^32.
    localparam logic [33:0] PI_Q32     = 34'd13493037704;
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

    localparam logic [30:0] TRIG_ONE = 31'h4000_0000;

    // One squared in Q.44, its hundredth, and the smallest hemisphere height.
    localparam logic [44:0] ONE_SQ   = 45'd17592186044416;
    localparam logic [44:0] FLOOR_SQ = 45'd175921860444;
    localparam logic [22:0] Z_FLOOR  = 23'd419430;

    typedef struct packed {
        logic        op;
        logic [23:0] u_radius;
        logic [23:0] u_angle;
    } chs_in_t;

    typedef struct packed {
        logic signed [23:0] x_out;
        logic signed [23:0] y_out;
        logic        [22:0] z_out;
        logic        [20:0] pdf_out;
    } chs_out_t;

    // Reciprocals ceil(2^k/d) for the Taylor divisors, exact for dividends below 2^30.
    function automatic logic [30:0] sin_recip(input int j);
        logic [30:0] m;
        unique case (j)
            0: m = 31'd1249445032;  // 110
            1: m = 31'd1908874354;  // 72
            2: m = 31'd1636178018;  // 42
            3: m = 31'd1717986919;  // 20
            4: m = 31'd1431655766;  // 6
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic int sin_shift(input int j);
        int k;
        unique case (j)
            0: k = 37;
            1: k = 37;
            2: k = 36;
            3: k = 35;
            4: k = 33;
            default: k = 0;
        endcase
        return k;
    endfunction

    function automatic logic [30:0] cos_recip(input int j);
        logic [30:0] m;
        unique case (j)
            0: m = 31'd2082408386;  // 132
            1: m = 31'd1527099484;  // 90
            2: m = 31'd1227133514;  // 56
            3: m = 31'd1145324613;  // 30
            4: m = 31'd1431655766;  // 12
            5: m = 31'd1073741824;  // 2
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic int cos_shift(input int j);
        int k;
        unique case (j)
            0: k = 38;
            1: k = 37;
            2: k = 36;
            3: k = 35;
            4: k = 34;
            5: k = 31;
            default: k = 0;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/chs_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// A sideband word travels alongside; no package dependencies.
module chs_isqrt #(
    parameter int ROOT_W = 22,
    parameter int SIDE_W = 25
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_value,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    logic                valid_reg [ROOT_W];
    logic [ROOT_W-1:0]   root_reg  [ROOT_W];
    logic [SIDE_W-1:0]   side_reg  [ROOT_W];
    logic [ROOT_W:0]     rem_reg   [ROOT_W-1];
    logic [2*ROOT_W-1:0] val_reg   [ROOT_W-1];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic                valid_p;
        logic [ROOT_W-1:0]   root_p;
        logic [SIDE_W-1:0]   side_p;
        logic [ROOT_W:0]     rem_p;
        logic [2*ROOT_W-1:0] val_p;
        logic [ROOT_W+1:0]   rem_c;
        logic [ROOT_W+1:0]   trial;
        logic                ge;
        logic [ROOT_W+1:0]   rem_next;
        logic [ROOT_W-1:0]   root_next;

        if (i == 0) begin : g_first
            assign valid_p = in_valid;
            assign root_p  = '0;
            assign side_p  = in_side;
            assign rem_p   = '0;
            assign val_p   = in_value;
        end else begin : g_rest
            assign valid_p = valid_reg[i-1];
            assign root_p  = root_reg[i-1];
            assign side_p  = side_reg[i-1];
            assign rem_p   = rem_reg[i-1];
            assign val_p   = val_reg[i-1];
        end

        // Bring down the next two bits and try the candidate root bit.
        always_comb begin
            rem_c     = {rem_p[ROOT_W-1:0], val_p[2*ROOT_W-1 -: 2]};
            trial     = {root_p, 2'b01};
            ge        = (rem_c >= trial);
            rem_next  = ge ? (rem_c - trial) : rem_c;
            root_next = {root_p[ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[i] <= root_next;
                side_reg[i] <= side_p;
            end
        end

        if (i < ROOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next[ROOT_W:0];
                    val_reg[i] <= val_p << 2;
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// File: hw/rtl/cosine_hemisphere_sampler.sv
// Top level of the cosine hemisphere sampler: warps two uniform numbers to a
// disk point and, in hemisphere mode, a height and density. Uses chs_pkg and chs_isqrt.
//
//   channel | ports                       | word
//   --------+-----------------------------+-----------------------------
//   input   | s_valid, s_ready, s_data    | chs_in_t  (op, u_radius, u_angle)
//   result  | m_valid, m_ready, m_data    | chs_out_t (x, y, z, pdf)
//
// One word is taken every cycle unless a full output register is not being read.
// The pipeline holds the two bit-serial square roots (22 and 23 stages) and
// the six Horner steps of the sine and cosine series (two stages each).
// Reset is synchronous and active low; it clears only the valid bits.
// The whole pipeline advances together whenever the output register is empty or
// being read, so a stall on the result side freezes every stage in place.
module cosine_hemisphere_sampler
    import chs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  chs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output chs_out_t m_data
);

    typedef struct packed {
        logic        op;
        logic [2:0]  oct;
        logic [21:0] r;
        logic [29:0] a;
        logic [29:0] a2;
    } trig_side_t;

    logic     adv;
    logic     m_valid_reg;
    chs_out_t m_data_reg;
    chs_out_t m_data_next;

    // Advance the whole pipeline when the output register can take a word.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Radius: r = floor(sqrt(u_radius * 2^20)), Q0.22.
    logic        r_valid;
    logic [21:0] r_root;
    logic [24:0] r_side;

    chs_isqrt #(
        .ROOT_W(22),
        .SIDE_W(25)
    ) u_sqrt_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_value  ({s_data.u_radius, 20'd0}),
        .in_side   ({s_data.op, s_data.u_angle}),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // Angle reduction: octant plus a remainder mirrored in odd octants, then
    // multiplied by pi in two halves so that each product stays narrow.
    logic        t1_valid_reg, t1_op_reg;
    logic [2:0]  t1_oct_reg;
    logic [21:0] t1_r_reg;
    logic [38:0] t1_lo_reg, t1_hi_reg;
    logic [21:0] rem_next;
    logic [38:0] t1_lo_next, t1_hi_next;

    always_comb begin
        rem_next   = r_side[21] ? (22'h200000 - {1'b0, r_side[20:0]})
                                : {1'b0, r_side[20:0]};
        t1_lo_next = 39'(rem_next * PI_Q32[16:0]);
        t1_hi_next = 39'(rem_next * PI_Q32[33:17]);
    end

    logic        t2_valid_reg, t2_op_reg;
    logic [2:0]  t2_oct_reg;
    logic [21:0] t2_r_reg;
    logic [29:0] t2_a_reg;
    logic [56:0] t2_sum;
    logic [29:0] t2_a_next;

    always_comb begin
        t2_sum    = {1'b0, t1_hi_reg, 17'd0} + {18'd0, t1_lo_reg};
        t2_a_next = t2_sum[54:25];
    end

    logic        t3_valid_reg, t3_op_reg;
    logic [2:0]  t3_oct_reg;
    logic [21:0] t3_r_reg;
    logic [29:0] t3_a_reg;
    logic [59:0] t3_aa_reg;

    logic       t4_valid_reg;
    trig_side_t t4_side_reg;
    trig_side_t t4_side_next;

    always_comb begin
        t4_side_next.op  = t3_op_reg;
        t4_side_next.oct = t3_oct_reg;
        t4_side_next.r   = t3_r_reg;
        t4_side_next.a   = t3_a_reg;
        t4_side_next.a2  = t3_aa_reg[59:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
        end else if (adv) begin
            t1_valid_reg <= r_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_op_reg   <= r_side[24];
            t1_oct_reg  <= r_side[23:21];
            t1_r_reg    <= r_root;
            t1_lo_reg   <= t1_lo_next;
            t1_hi_reg   <= t1_hi_next;
            t2_op_reg   <= t1_op_reg;
            t2_oct_reg  <= t1_oct_reg;
            t2_r_reg    <= t1_r_reg;
            t2_a_reg    <= t2_a_next;
            t3_op_reg   <= t2_op_reg;
            t3_oct_reg  <= t2_oct_reg;
            t3_r_reg    <= t2_r_reg;
            t3_a_reg    <= t2_a_reg;
            t3_aa_reg   <= 60'(t2_a_reg * t2_a_reg);
            t4_side_reg <= t4_side_next;
        end
    end

    // Horner steps of the sine and cosine series. Each step multiplies the
    // running term by a^2 in one stage and divides by the series constant with
    // a reciprocal multiply in the next. The last sine step multiplies by a instead and does not divide.
    logic       a_valid_reg [NSTEP];
    trig_side_t a_side_reg  [NSTEP];
    logic [60:0] cprod_reg  [NSTEP];
    logic [60:0] sprod_reg  [NSTEP];
    logic       b_valid_reg [NSTEP];
    trig_side_t b_side_reg  [NSTEP];
    logic [60:0] cq_reg     [NSTEP];
    logic [60:0] sq_reg     [NSTEP];

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        logic        valid_p;
        trig_side_t  side_p;
        logic [30:0] tc, ts;
        logic [60:0] cq_sh, sq_sh;
        logic [29:0] s_op;
        logic [60:0] cprod_next, sprod_next, cq_next, sq_next;

        if (j == 0) begin : g_first
            assign valid_p = t4_valid_reg;
            assign side_p  = t4_side_reg;
            assign cq_sh   = '0;
            assign sq_sh   = '0;
            assign tc      = TRIG_ONE;
            assign ts      = TRIG_ONE;
        end else begin : g_rest
            assign valid_p = b_valid_reg[j-1];
            assign side_p  = b_side_reg[j-1];
            assign cq_sh   = cq_reg[j-1] >> cos_shift(j-1);
            assign sq_sh   = sq_reg[j-1] >> sin_shift(j-1);
            assign tc      = TRIG_ONE - cq_sh[30:0];
            assign ts      = TRIG_ONE - sq_sh[30:0];
        end

        assign s_op       = (j == NSTEP - 1) ? side_p.a : side_p.a2;
        assign cprod_next = 61'(side_p.a2 * tc);
        assign sprod_next = 61'(s_op * ts);
        assign cq_next    = 61'(cprod_reg[j][59:30] * cos_recip(j));

        if (j == NSTEP - 1) begin : g_sin_last
            assign sq_next = {30'd0, sprod_reg[j][60:30]};
        end else begin : g_sin_div
            assign sq_next = 61'(sprod_reg[j][59:30] * sin_recip(j));
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                a_valid_reg[j] <= 1'b0;
                b_valid_reg[j] <= 1'b0;
            end else if (adv) begin
                a_valid_reg[j] <= valid_p;
                b_valid_reg[j] <= a_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                a_side_reg[j] <= side_p;
                cprod_reg[j]  <= cprod_next;
                sprod_reg[j]  <= sprod_next;
                b_side_reg[j] <= a_side_reg[j];
                cq_reg[j]     <= cq_next;
                sq_reg[j]     <= sq_next;
            end
        end
    end

    // Octant symmetry picks and signs the cosine and sine magnitudes.
    logic [60:0] c_sh;
    logic [30:0] c_fin, s_fin;
    logic        swap, cneg_next, sneg_next;
    logic [2:0]  oct5, oct_inc, oct_dec;

    always_comb begin
        c_sh      = cq_reg[NSTEP-1] >> cos_shift(NSTEP-1);
        c_fin     = TRIG_ONE - c_sh[30:0];
        s_fin     = sq_reg[NSTEP-1][30:0];
        oct5      = b_side_reg[NSTEP-1].oct;
        oct_inc   = oct5 + 3'd1;
        oct_dec   = oct5 - 3'd2;
        swap      = oct_inc[1];
        cneg_next = !oct_dec[2];
        sneg_next = oct5[2];
    end

    logic        x1_valid_reg, x1_op_reg, x1_cneg_reg, x1_sneg_reg;
    logic [21:0] x1_r_reg;
    logic [30:0] x1_cmag_reg, x1_smag_reg;

    logic        x2_valid_reg, x2_op_reg, x2_cneg_reg, x2_sneg_reg;
    logic [52:0] x2_xp_reg, x2_yp_reg;

    logic        x3_valid_reg, x3_op_reg, x3_cneg_reg, x3_sneg_reg;
    logic [21:0] x3_xm_reg, x3_ym_reg;

    logic               x4_valid_reg, x4_op_reg;
    logic [43:0]        x4_xx_reg, x4_yy_reg;
    logic signed [23:0] x4_x_reg, x4_y_reg;
    logic signed [23:0] x4_x_next, x4_y_next;

    always_comb begin
        x4_x_next = x3_cneg_reg ? (24'sd0 - $signed({2'b00, x3_xm_reg}))
                                : $signed({2'b00, x3_xm_reg});
        x4_y_next = x3_sneg_reg ? (24'sd0 - $signed({2'b00, x3_ym_reg}))
                                : $signed({2'b00, x3_ym_reg});
    end

    // Height argument: 1 - x^2 - y^2, clamped below at one hundredth.
    logic               x5_valid_reg, x5_op_reg;
    logic [44:0]        x5_sq_reg;
    logic signed [23:0] x5_x_reg, x5_y_reg;
    logic [44:0]        tot, x5_sq_next;

    always_comb begin
        tot = {1'b0, x4_xx_reg} + {1'b0, x4_yy_reg};
        x5_sq_next = (tot >= ONE_SQ) ? '0 : (ONE_SQ - tot);
        if (x5_sq_next < FLOOR_SQ) begin
            x5_sq_next = FLOOR_SQ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
            x3_valid_reg <= 1'b0;
            x4_valid_reg <= 1'b0;
            x5_valid_reg <= 1'b0;
        end else if (adv) begin
            x1_valid_reg <= b_valid_reg[NSTEP-1];
            x2_valid_reg <= x1_valid_reg;
            x3_valid_reg <= x2_valid_reg;
            x4_valid_reg <= x3_valid_reg;
            x5_valid_reg <= x4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_op_reg   <= b_side_reg[NSTEP-1].op;
            x1_r_reg    <= b_side_reg[NSTEP-1].r;
            x1_cmag_reg <= swap ? s_fin : c_fin;
            x1_smag_reg <= swap ? c_fin : s_fin;
            x1_cneg_reg <= cneg_next;
            x1_sneg_reg <= sneg_next;
            x2_op_reg   <= x1_op_reg;
            x2_cneg_reg <= x1_cneg_reg;
            x2_sneg_reg <= x1_sneg_reg;
            x2_xp_reg   <= 53'(x1_r_reg * x1_cmag_reg);
            x2_yp_reg   <= 53'(x1_r_reg * x1_smag_reg);
            x3_op_reg   <= x2_op_reg;
            x3_cneg_reg <= x2_cneg_reg;
            x3_sneg_reg <= x2_sneg_reg;
            x3_xm_reg   <= x2_xp_reg[51:30];
            x3_ym_reg   <= x2_yp_reg[51:30];
            x4_op_reg   <= x3_op_reg;
            x4_xx_reg   <= 44'(x3_xm_reg * x3_xm_reg);
            x4_yy_reg   <= 44'(x3_ym_reg * x3_ym_reg);
            x4_x_reg    <= x4_x_next;
            x4_y_reg    <= x4_y_next;
            x5_op_reg   <= x4_op_reg;
            x5_sq_reg   <= x5_sq_next;
            x5_x_reg    <= x4_x_reg;
            x5_y_reg    <= x4_y_reg;
        end
    end

    // Height: z = floor(sqrt(argument)), up to exactly one, so 23 bits.
    logic        z_valid;
    logic [22:0] z_root;
    logic [48:0] z_side;

    chs_isqrt #(
        .ROOT_W(23),
        .SIDE_W(49)
    ) u_sqrt_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (x5_valid_reg),
        .in_value  ({1'b0, x5_sq_reg}),
        .in_side   ({x5_op_reg, x5_x_reg, x5_y_reg}),
        .out_valid (z_valid),
        .out_root  (z_root),
        .out_side  (z_side)
    );

    // Density z/pi, then the output register. Disk mode zeroes z and pdf.
    logic        x6_valid_reg, x6_op_reg;
    logic [22:0] x6_z_reg;
    logic [53:0] x6_pp_reg;
    logic [47:0] x6_xy_reg;

    always_comb begin
        m_data_next.x_out   = $signed(x6_xy_reg[47:24]);
        m_data_next.y_out   = $signed(x6_xy_reg[23:0]);
        m_data_next.z_out   = x6_op_reg ? x6_z_reg : '0;
        m_data_next.pdf_out = x6_op_reg ? x6_pp_reg[52:32] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x6_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            x6_valid_reg <= z_valid;
            m_valid_reg  <= x6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x6_op_reg  <= z_side[48];
            x6_xy_reg  <= z_side[47:0];
            x6_z_reg   <= z_root;
            x6_pp_reg  <= 54'(z_root * INV_PI_Q32);
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // A zero height only comes from disk mode, where the density is zero too.
    a_pdf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.z_out == '0) |-> (m_data.pdf_out == '0))
        else $error("density nonzero with zero height");

    // A hemisphere height never drops below one tenth and never exceeds one.
    a_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.z_out != '0) |->
            (m_data.z_out >= Z_FLOOR) && (m_data.z_out <= 23'd4194304))
        else $error("height out of range");

    // The disk point stays within the square from minus one to one on each axis.
    a_xy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.x_out >= -24'sd4194304) && (m_data.x_out <= 24'sd4194304)
                 && (m_data.y_out >= -24'sd4194304) && (m_data.y_out <= 24'sd4194304))
        else $error("disk coordinate out of range");
`endif

endmodule
